@@ design/accumulator_cpu_step_top_defines.svh @@
// Assertion macros used by the port-level checker
`ifndef ACCUMULATOR_CPU_STEP_TOP_DEFINES_SVH
`define ACCUMULATOR_CPU_STEP_TOP_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define ACS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle
`define ACS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ design/acs_pkg.sv @@
// Package with types, codes and ALU function for the accumulator CPU step
package acs_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_EXEC  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEMRD,
        ST_FETCH,
        ST_DECODE,
        ST_OPRD,
        ST_EXEC,
        ST_DONE
    } state_t;

    // Memory address sources
    typedef enum logic [1:0] {
        MA_ADDR,
        MA_PC,
        MA_OPER
    } maddr_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       capture;   // latch input item
        logic       mem_rd;    // issue memory read
        maddr_sel_t mem_sel;
        logic       mem_wr_in; // write data field at addr
        logic       rd_capt;   // latch read data for a read item
        logic       fetch;     // take instruction byte, bump pc_lo
        logic       exec;      // perform the instruction
        logic       out_load;  // load output register
    } acs_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic halted;
        logic need_oper; // decoded instruction needs a memory operand
    } acs_sts_t;

    localparam logic [7:0] GLOBAL_BASE = 8'd128;
    localparam logic [7:0] STACK_BASE  = 8'd192;

    // ALU: one of sixteen functions plus signed offset in the high nibble
    function automatic logic [7:0] alu_calc(input logic [7:0] fn,
                                            input logic [7:0] a,
                                            input logic [7:0] b);
        logic [7:0] r;
        logic [8:0] s;
        logic [7:0] offs;
        s = {1'b0, a} + {1'b0, b};
        offs = {{4{fn[7]}}, fn[7:4]};
        unique case (fn[3:0])
            4'd0:  r = a;
            4'd1:  r = b;
            4'd2:  r = ~a;
            4'd3:  r = ~b;
            4'd4:  r = {a[6:0], 1'b0};
            4'd5:  r = {b[6:0], 1'b0};
            4'd6:  r = {1'b0, a[7:1]};
            4'd7:  r = {1'b0, b[7:1]};
            4'd8:  r = a & b;
            4'd9:  r = a | b;
            4'd10: r = a ^ b;
            4'd11: r = s[7:0];
            4'd12: r = {7'd0, s[8]};
            4'd13: r = (a < b) ? 8'hFF : 8'h00;
            4'd14: r = (a == b) ? 8'hFF : 8'h00;
            default: r = (a > b) ? 8'hFF : 8'h00;
        endcase
        return r + offs;
    endfunction

endpackage

@@ design/acs_ctrl.sv @@
// Controller state machine sequencing the shared memory port
module acs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    output logic             stall_in,
    output logic             valid_out,
    input  logic             stall_out,
    input  logic [1:0]       func,
    output acs_pkg::acs_cmd_t cmd,
    input  acs_pkg::acs_sts_t sts
);
    import acs_pkg::*;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;
    logic   take;

    assign take = valid_in && !stall_in;
    // Input taken only when idle; output register parts the sides
    assign stall_in = (state_reg != ST_IDLE);
    assign valid_out = ovalid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    priority if (func == FUNC_READ)
                        state_next = ST_MEMRD;
                    else if (func == FUNC_EXEC && !sts.halted)
                        state_next = ST_FETCH;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_MEMRD:  state_next = ST_DONE;
            ST_FETCH:  state_next = ST_DECODE;
            ST_DECODE: state_next = sts.need_oper ? ST_OPRD : ST_EXEC;
            ST_OPRD:   state_next = ST_EXEC;
            ST_EXEC:   state_next = ST_DONE;
            ST_DONE:   if (!ovalid_reg || !stall_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        cmd.mem_sel = MA_ADDR;
        ovalid_next = ovalid_reg && stall_out;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = take;
                if (take && func == FUNC_WRITE) cmd.mem_wr_in = 1'b1;
                if (take && func == FUNC_READ)
                begin
                    cmd.mem_rd  = 1'b1;
                    cmd.mem_sel = MA_ADDR;
                end
                if (take && func == FUNC_EXEC && !sts.halted)
                begin
                    cmd.mem_rd  = 1'b1;
                    cmd.mem_sel = MA_PC;
                end
            end
            ST_MEMRD: cmd.rd_capt = 1'b1;
            ST_FETCH: cmd.fetch = 1'b1;
            ST_DECODE:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.mem_sel = MA_OPER;
            end
            ST_EXEC: cmd.exec = 1'b1;
            ST_DONE:
            begin
                if (!ovalid_reg || !stall_out)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

@@ design/acs_dpath.sv @@
// Datapath: memory, registers, ALU and output register
module acs_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  acs_pkg::acs_cmd_t cmd,
    output acs_pkg::acs_sts_t sts,
    input  logic [15:0]       addr,
    input  logic [7:0]        data,
    input  logic [7:0]        parallel_in,
    input  logic              serial_in_bit,
    output logic [15:0]       pc,
    output logic [7:0]        acc_a_out,
    output logic [7:0]        acc_b_out,
    output logic              zero_out,
    output logic              halted_out,
    output logic              serial_out_bit,
    output logic              serial_clock_out,
    output logic              bus_released,
    output logic [7:0]        parallel_out,
    output logic [7:0]        device_select_out,
    output logic [7:0]        read_data
);
    import acs_pkg::*;

    logic [7:0] mem [0:65535];
    logic [7:0] mrd_reg;

    logic [15:0] addr_reg;
    logic [7:0]  data_reg, pin_reg;
    logic        sin_reg;
    logic [7:0]  ins_reg;

    logic [7:0] pc_lo_reg, pc_hi_reg, ret_lo_reg, ret_hi_reg;
    logic [7:0] page_reg, dsel_reg, gpage_reg, spage_reg;
    logic [7:0] a_reg, b_reg, fn_reg, held_reg;
    logic       selb_reg, frozen_reg, zero_reg;
    logic [7:0] sin_sh_reg, sout_sh_reg, latch_reg;
    logic       sclk_reg, busoff_reg, halted_reg;
    logic       sout_reg;
    logic [7:0] rd_reg;

    // Operand address, computed from decoded instruction
    logic [7:0] eff_w, eff_pg, op_hi, op_lo;
    logic [15:0] mem_a;
    logic [3:0] dst;
    logic [2:0] src;
    logic       is_sig, is_gp, pseudo_mem;

    assign dst = ins_reg[3:0];
    assign src = ins_reg[6:4];
    assign is_sig = !ins_reg[7];
    assign is_gp  = ins_reg[7] && ins_reg[6];
    assign eff_w = selb_reg ? b_reg : a_reg;
    always_comb
    begin
        priority if (eff_w < GLOBAL_BASE) eff_pg = page_reg;
        else if (eff_w < STACK_BASE)      eff_pg = gpage_reg;
        else                              eff_pg = spage_reg;
    end
    // Pseudo M used as source or destination of a plain transfer
    assign pseudo_mem = is_sig && dst != 4'd0 &&
                        !(dst == 4'd2 && (src == 3'd0 || src == 3'd2)) &&
                        (src == 3'd2 || dst == 4'd2);
    always_comb
    begin
        if (is_gp)
        begin
            op_hi = ins_reg[4] ? spage_reg : gpage_reg;
            op_lo = (ins_reg[4] ? STACK_BASE : GLOBAL_BASE) + {5'd0, ins_reg[2:0]};
        end
        else if (pseudo_mem)
        begin
            op_hi = eff_pg;
            op_lo = eff_w;
        end
        else
        begin
            // Immediate operand at pc
            op_hi = pc_hi_reg;
            op_lo = pc_lo_reg;
        end
    end
    assign sts.need_oper = is_gp || (is_sig && dst != 4'd0);
    assign sts.halted = halted_reg;

    always_comb
    begin
        unique case (cmd.mem_sel)
            MA_PC:   mem_a = {pc_hi_reg, pc_lo_reg};
            MA_OPER: mem_a = {op_hi, op_lo};
            default: mem_a = addr;
        endcase
    end

    // Memory: one port
    logic        wr_en;
    logic [15:0] wr_a;
    logic [7:0]  wr_d;
    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_a] <= wr_d;
        if (cmd.mem_rd) mrd_reg <= mem[mem_a];
    end

    // ALU evaluation
    logic [7:0] alu_res;
    assign alu_res = alu_calc(fn_reg, a_reg, b_reg);

    // Source value
    logic [7:0] srcv, alu_now;
    assign alu_now = frozen_reg ? held_reg : alu_res;
    always_comb
    begin
        unique case (src)
            3'd0: srcv = mrd_reg;
            3'd1: srcv = page_reg;
            3'd2: srcv = mrd_reg;
            3'd3: srcv = ret_lo_reg;
            3'd4: srcv = ret_hi_reg;
            3'd5: srcv = sin_sh_reg;
            3'd6: srcv = pin_reg;
            default: srcv = alu_now;
        endcase
    end

    // Execute: next state of architectural registers
    logic [7:0] pc_lo_n, pc_hi_n, ret_lo_n, ret_hi_n, page_n, dsel_n, gpage_n, spage_n;
    logic [7:0] a_n, b_n, fn_n, held_n, sin_sh_n, sout_sh_n, latch_n, v;
    logic       selb_n, frozen_n, zero_n, sclk_n, busoff_n, halted_n, sout_n;
    logic       z_eval, src_alu;
    logic [7:0] ga;
    always_comb
    begin
        pc_lo_n = pc_lo_reg; pc_hi_n = pc_hi_reg;
        ret_lo_n = ret_lo_reg; ret_hi_n = ret_hi_reg;
        page_n = page_reg; dsel_n = dsel_reg; gpage_n = gpage_reg; spage_n = spage_reg;
        a_n = a_reg; b_n = b_reg; fn_n = fn_reg; held_n = held_reg;
        sin_sh_n = sin_sh_reg; sout_sh_n = sout_sh_reg; latch_n = latch_reg;
        selb_n = selb_reg; frozen_n = frozen_reg; zero_n = zero_reg;
        sclk_n = sclk_reg; busoff_n = busoff_reg; halted_n = halted_reg;
        sout_n = 1'b0;
        wr_en = 1'b0; wr_a = addr_reg; wr_d = data_reg;
        v = srcv; z_eval = zero_reg;
        ga = ins_reg[5] ? b_reg : a_reg;
        src_alu = 1'b0;
        if (cmd.mem_wr_in)
        begin
            wr_en = 1'b1; wr_a = addr; wr_d = data;
        end
        if (cmd.fetch) pc_lo_n = pc_lo_reg + 8'd1;
        if (cmd.exec)
        begin
            if (is_sig)
            begin
                if (dst == 4'd0)
                begin
                    unique case (src)
                        3'd1: sin_sh_n = {sin_sh_reg[6:0], sin_reg};
                        3'd2:
                        begin
                            sout_n = sout_sh_reg[7];
                            sout_sh_n = {sout_sh_reg[6:0], 1'b0};
                        end
                        3'd3: sclk_n = 1'b0;
                        3'd4: sclk_n = 1'b1;
                        3'd5: busoff_n = 1'b1;
                        3'd6: spage_n = spage_reg + 8'd1;
                        3'd7: spage_n = spage_reg - 8'd1;
                        default: ;
                    endcase
                end
                else if (dst == 4'd2 && src == 3'd0)
                begin
                    pc_lo_n = ret_lo_reg; pc_hi_n = ret_hi_reg;
                end
                else if (dst == 4'd2 && src == 3'd2)
                begin
                    pc_hi_n = pc_hi_reg + 8'd1; pc_lo_n = 8'd0;
                end
                else
                begin
                    if (src == 3'd0) pc_lo_n = pc_lo_reg + 8'd1;
                    // Source ALU evaluation updates held and zero
                    if (src == 3'd7 && !frozen_reg)
                    begin
                        src_alu = 1'b1;
                        held_n = alu_res;
                        zero_n = (alu_res == 8'd0);
                    end
                    unique case (dst)
                        4'd1: page_n = v;
                        4'd2:
                        begin
                            wr_en = 1'b1; wr_a = {eff_pg, eff_w}; wr_d = v;
                        end
                        4'd3: ret_lo_n = v;
                        4'd4: ret_hi_n = v;
                        4'd5:
                        begin
                            sout_sh_n = v; halted_n = 1'b1;
                        end
                        4'd6:
                        begin
                            busoff_n = 1'b0; latch_n = v;
                        end
                        4'd7:
                        begin
                            fn_n = v; frozen_n = 1'b0;
                            held_n = alu_calc(v, a_reg, b_reg);
                            zero_n = (held_n == 8'd0);
                        end
                        4'd8: dsel_n = v;
                        4'd9: gpage_n = v;
                        4'd10: pc_lo_n = v;
                        4'd11, 4'd12:
                        begin
                            // Second evaluation sees state after the source one
                            if (!frozen_reg)
                            begin
                                held_n = alu_res;
                                z_eval = (alu_res == 8'd0);
                                zero_n = z_eval;
                            end
                            else
                                z_eval = src_alu ? zero_n : zero_reg;
                            if ((dst == 4'd11) ? !z_eval : z_eval) pc_lo_n = v;
                        end
                        4'd13:
                        begin
                            ret_lo_n = (src == 3'd0) ? pc_lo_reg + 8'd1 : pc_lo_reg;
                            ret_hi_n = pc_hi_reg;
                            pc_lo_n = 8'd0; pc_hi_n = v;
                        end
                        4'd14:
                        begin
                            a_n = v; selb_n = 1'b0; frozen_n = 1'b1;
                        end
                        4'd15:
                        begin
                            b_n = v; selb_n = 1'b1; frozen_n = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            else if (is_gp)
            begin
                if (ins_reg[3])
                begin
                    wr_en = 1'b1; wr_a = {op_hi, op_lo}; wr_d = ga;
                end
                else if (ins_reg[5]) b_n = mrd_reg;
                else a_n = mrd_reg;
            end
            else
            begin
                ret_lo_n = pc_lo_reg; ret_hi_n = pc_hi_reg;
                pc_lo_n = 8'd0; pc_hi_n = {2'd0, ins_reg[5:0]};
            end
        end
    end

    // Input capture and instruction register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= addr;
            data_reg <= data;
            pin_reg  <= parallel_in;
            sin_reg  <= serial_in_bit;
        end
        if (cmd.fetch) ins_reg <= mrd_reg;
    end

    // Architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_lo_reg <= '0; pc_hi_reg <= '0; ret_lo_reg <= '0; ret_hi_reg <= '0;
            page_reg <= '0; dsel_reg <= '0; gpage_reg <= '0; spage_reg <= '0;
            a_reg <= '0; b_reg <= '0; fn_reg <= '0; held_reg <= '0;
            selb_reg <= 1'b0; frozen_reg <= 1'b0; zero_reg <= 1'b0;
            sin_sh_reg <= '0; sout_sh_reg <= '0; latch_reg <= '0;
            sclk_reg <= 1'b0; busoff_reg <= 1'b1; halted_reg <= 1'b0;
            sout_reg <= 1'b0; rd_reg <= '0;
        end
        else
        begin
            pc_lo_reg <= pc_lo_n; pc_hi_reg <= pc_hi_n;
            ret_lo_reg <= ret_lo_n; ret_hi_reg <= ret_hi_n;
            page_reg <= page_n; dsel_reg <= dsel_n; gpage_reg <= gpage_n;
            spage_reg <= spage_n;
            a_reg <= a_n; b_reg <= b_n; fn_reg <= fn_n; held_reg <= held_n;
            selb_reg <= selb_n; frozen_reg <= frozen_n; zero_reg <= zero_n;
            sin_sh_reg <= sin_sh_n; sout_sh_reg <= sout_sh_n; latch_reg <= latch_n;
            sclk_reg <= sclk_n; busoff_reg <= busoff_n; halted_reg <= halted_n;
            if (cmd.capture)
            begin
                sout_reg <= 1'b0;
                rd_reg   <= '0;
            end
            if (cmd.exec) sout_reg <= sout_n;
            if (cmd.rd_capt) rd_reg <= mrd_reg;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pc <= {pc_hi_reg, pc_lo_reg};
            acc_a_out <= a_reg;
            acc_b_out <= b_reg;
            zero_out <= zero_reg;
            halted_out <= halted_reg;
            serial_out_bit <= sout_reg;
            serial_clock_out <= sclk_reg;
            bus_released <= busoff_reg;
            parallel_out <= latch_reg;
            device_select_out <= dsel_reg;
            read_data <= rd_reg;
        end
    end
endmodule

@@ design/accumulator_cpu_step_top.sv @@
// Top level of the accumulator CPU step block
// Write, unused-code and halted execute items go from idle straight to the done state;
// read items pass the memory-read state; execute items pass fetch, decode, operand read
// (only with a memory operand) and execute. Input stalls until the result is loaded, and a
// stalled result holds the block in its last state. One memory port serves all accesses.
// Reset: asynchronous active low; architectural registers clear, bus released; memory is not cleared.
module accumulator_cpu_step_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] addr,
    input  logic [7:0]  data,
    input  logic [7:0]  parallel_in,
    input  logic        serial_in_bit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pc,
    output logic [7:0]  acc_a_out,
    output logic [7:0]  acc_b_out,
    output logic        zero_out,
    output logic        halted_out,
    output logic        serial_out_bit,
    output logic        serial_clock_out,
    output logic        bus_released,
    output logic [7:0]  parallel_out,
    output logic [7:0]  device_select_out,
    output logic [7:0]  read_data
);
    import acs_pkg::*;

    acs_cmd_t cmd;
    acs_sts_t sts;

    acs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .valid_in(in_valid), .stall_in(in_stall),
        .valid_out(out_valid), .stall_out(out_stall),
        .func(func), .cmd(cmd), .sts(sts)
    );

    acs_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .addr(addr), .data(data),
        .parallel_in(parallel_in), .serial_in_bit(serial_in_bit),
        .pc(pc), .acc_a_out(acc_a_out), .acc_b_out(acc_b_out),
        .zero_out(zero_out), .halted_out(halted_out),
        .serial_out_bit(serial_out_bit), .serial_clock_out(serial_clock_out),
        .bus_released(bus_released), .parallel_out(parallel_out),
        .device_select_out(device_select_out), .read_data(read_data)
    );
endmodule

@@ design/acs_checker.sv @@
// Port-level checker for the accumulator CPU step block, with its bind
`include "accumulator_cpu_step_top_defines.svh"
module acs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        halted_out,
    input logic [15:0] pc
);
    // A stalled result holds
    `ACS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pc), "result dropped under stall")
    // Halt is sticky across results
    `ACS_ASSERT_NEXT(a_halt_sticky, clk, rst_n, out_valid && halted_out, halted_out, "halt flag cleared")
    // An accepted transaction blocks the input next cycle
    `ACS_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled while busy")
endmodule

bind accumulator_cpu_step_top acs_checker u_acs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .halted_out(halted_out), .pc(pc)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the accumulator CPU step block
module tb_top;
    import acs_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEM_TARGET    = 1650;

    // SIGNAL destination codes
    localparam logic [3:0] D_CTRL = 4'd0,  D_PAGE = 4'd1,  D_MEM = 4'd2,  D_RLO = 4'd3;
    localparam logic [3:0] D_RHI  = 4'd4,  D_SER  = 4'd5,  D_BUS = 4'd6,  D_ALUF = 4'd7;
    localparam logic [3:0] D_DEV  = 4'd8,  D_GLOB = 4'd9,  D_JMP = 4'd10, D_JNZ = 4'd11;
    localparam logic [3:0] D_JZ   = 4'd12, D_CALL = 4'd13, D_A   = 4'd14, D_B = 4'd15;
    // SIGNAL source codes
    localparam logic [2:0] S_IMM = 3'd0, S_PAGE = 3'd1, S_MEM = 3'd2, S_RLO = 3'd3;
    localparam logic [2:0] S_RHI = 3'd4, S_SIN  = 3'd5, S_PIN = 3'd6, S_ALU = 3'd7;
    // Control ops (destination zero)
    localparam logic [2:0] C_SSI = 3'd1, C_SSO = 3'd2, C_SCL = 3'd3, C_SCH = 3'd4;
    localparam logic [2:0] C_BOFF = 3'd5, C_ENTER = 3'd6, C_LEAVE = 3'd7;
    // Instruction class bits
    localparam logic [7:0] OP_TRAP = 8'h80, OP_GETPUT = 8'hC0;
    localparam logic [7:0] GP_STORE = 8'h08, GP_LOCAL = 8'h10, GP_ACCB = 8'h20;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  a;
        logic [7:0]  b;
        logic        z;
        logic        h;
        logic        so;
        logic        sc;
        logic        br;
        logic [7:0]  po;
        logic [7:0]  ds;
        logic [7:0]  rd;
    } cpu_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  parallel_in;
    logic        serial_in_bit;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] pc;
    logic [7:0]  acc_a_out;
    logic [7:0]  acc_b_out;
    logic        zero_out;
    logic        halted_out;
    logic        serial_out_bit;
    logic        serial_clock_out;
    logic        bus_released;
    logic [7:0]  parallel_out;
    logic [7:0]  device_select_out;
    logic [7:0]  read_data;

    accumulator_cpu_step_top dut (.*);

    // Predicted CPU state
    bit [7:0]  cpu_mem [0:65535];
    bit        cpu_written [0:65535];
    bit [15:0] written_addrs [$];
    bit [7:0] pcl, pch, rlo, rhi, pgr, dsel, gpage, spage, ra, rb;
    bit       sel_b, frozen, zflag, sclk, boff, halt;
    bit [7:0] alu_fn, alu_hold, sin_sh, sout_sh, plat;

    cpu_res_t expected_q [$];
    int       n_err;
    int       n_sent;
    bit       no_gaps;
    int       rx_wait;
    int       rx_hold;
    int       idle_cycles;

    // Clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic bit [7:0] fetch_byte();
        bit [7:0] v;
        v = cpu_mem[{pch, pcl}];
        pcl = pcl + 8'd1;
        return v;
    endfunction

    // Address used by the M pseudo-register
    function automatic bit [15:0] indirect_addr();
        bit [7:0] w;
        bit [7:0] pg;
        w = sel_b ? rb : ra;
        if (w < 8'd128)
            pg = pgr;
        else if (w < 8'd192)
            pg = gpage;
        else
            pg = spage;
        return {pg, w};
    endfunction

    // ALU evaluation; holds its result while frozen
    function automatic bit [7:0] alu_eval_model();
        bit [7:0] r;
        bit [7:0] ofs;
        bit [8:0] sum;
        if (frozen)
            return alu_hold;
        ofs = {{4{alu_fn[7]}}, alu_fn[7:4]};
        sum = ra + rb;
        case (alu_fn[3:0])
            4'd0:  r = ra;
            4'd1:  r = rb;
            4'd2:  r = ~ra;
            4'd3:  r = ~rb;
            4'd4:  r = ra << 1;
            4'd5:  r = rb << 1;
            4'd6:  r = ra >> 1;
            4'd7:  r = rb >> 1;
            4'd8:  r = ra & rb;
            4'd9:  r = ra | rb;
            4'd10: r = ra ^ rb;
            4'd11: r = sum[7:0];
            4'd12: r = {7'd0, sum[8]};
            4'd13: r = (ra < rb) ? 8'hFF : 8'h00;
            4'd14: r = (ra == rb) ? 8'hFF : 8'h00;
            default: r = (ra > rb) ? 8'hFF : 8'h00;
        endcase
        alu_hold = r + ofs;
        zflag = (alu_hold == 8'd0);
        return alu_hold;
    endfunction

    function automatic void call_page(bit [7:0] pg);
        rlo = pcl;
        pcl = 8'd0;
        rhi = pch;
        pch = pg;
    endfunction

    function automatic void mem_store(bit [15:0] a, bit [7:0] v);
        if (!cpu_written[a])
            written_addrs.push_back(a);
        cpu_written[a] = 1'b1;
        cpu_mem[a] = v;
    endfunction

    function automatic bit [7:0] pseudo_read(bit [2:0] src, bit [7:0] pin);
        case (src)
            S_IMM:  return fetch_byte();
            S_PAGE: return pgr;
            S_MEM:  return cpu_mem[indirect_addr()];
            S_RLO:  return rlo;
            S_RHI:  return rhi;
            S_SIN:  return sin_sh;
            S_PIN:  return pin;
            default: return alu_eval_model();
        endcase
    endfunction

    function automatic void pseudo_write(bit [3:0] dst, bit [7:0] v);
        bit [7:0] dummy;
        case (dst)
            D_PAGE: pgr = v;
            D_MEM:  mem_store(indirect_addr(), v);
            D_RLO:  rlo = v;
            D_RHI:  rhi = v;
            D_SER:  begin sout_sh = v; halt = 1'b1; end
            D_BUS:  begin boff = 1'b0; plat = v; end
            D_ALUF: begin alu_fn = v; frozen = 1'b0; dummy = alu_eval_model(); end
            D_DEV:  dsel = v;
            D_GLOB: gpage = v;
            D_JMP:  pcl = v;
            D_JNZ:  begin dummy = alu_eval_model(); if (!zflag) pcl = v; end
            D_JZ:   begin dummy = alu_eval_model(); if (zflag) pcl = v; end
            D_CALL: call_page(v);
            D_A:    begin ra = v; sel_b = 1'b0; frozen = 1'b1; end
            D_B:    begin rb = v; sel_b = 1'b1; frozen = 1'b1; end
            default: ;
        endcase
    endfunction

    // One item: returns the expected transaction on the result side
    function automatic cpu_res_t cpu_step(bit [1:0] f, bit [15:0] a, bit [7:0] d,
                                          bit [7:0] pin, bit sin);
        cpu_res_t r;
        bit [7:0] ins;
        bit [7:0] rdv;
        bit [7:0] lo;
        bit [7:0] pg;
        bit       so;
        rdv = 8'd0;
        so = 1'b0;
        if (f == FUNC_WRITE)
            mem_store(a, d);
        else if (f == FUNC_READ)
            rdv = cpu_mem[a];
        else if (f == FUNC_EXEC && !halt)
        begin
            ins = fetch_byte();
            if (!ins[7])
            begin
                if (ins[3:0] != D_CTRL)
                begin
                    if (ins[6:4] == S_IMM && ins[3:0] == D_MEM)
                    begin
                        pcl = rlo;
                        pch = rhi;
                    end
                    else if (ins[6:4] == S_MEM && ins[3:0] == D_MEM)
                    begin
                        pch = pch + 8'd1;
                        pcl = 8'd0;
                    end
                    else
                        pseudo_write(ins[3:0], pseudo_read(ins[6:4], pin));
                end
                else
                begin
                    case (ins[6:4])
                        C_SSI:   sin_sh = {sin_sh[6:0], sin};
                        C_SSO:   begin so = sout_sh[7]; sout_sh = sout_sh << 1; end
                        C_SCL:   sclk = 1'b0;
                        C_SCH:   sclk = 1'b1;
                        C_BOFF:  boff = 1'b1;
                        C_ENTER: spage = spage + 8'd1;
                        C_LEAVE: spage = spage - 8'd1;
                        default: ;
                    endcase
                end
            end
            else if (ins[6])
            begin
                pg = ins[4] ? spage : gpage;
                lo = (ins[4] ? STACK_BASE : GLOBAL_BASE) + {5'd0, ins[2:0]};
                if (ins[3])
                    mem_store({pg, lo}, ins[5] ? rb : ra);
                else if (ins[5])
                    rb = cpu_mem[{pg, lo}];
                else
                    ra = cpu_mem[{pg, lo}];
            end
            else
                call_page({2'b00, ins[5:0]});
        end
        r.pc = {pch, pcl};
        r.a = ra;
        r.b = rb;
        r.z = zflag;
        r.h = halt;
        r.so = so;
        r.sc = sclk;
        r.br = boff;
        r.po = plat;
        r.ds = dsel;
        r.rd = rdv;
        return r;
    endfunction

    function automatic bit is_halting(bit [7:0] ins);
        return !ins[7] && ins[3:0] == D_SER;
    endfunction

    // Send one transaction and record its prediction once accepted
    task automatic send_item(bit [1:0] f, bit [15:0] a, bit [7:0] d);
        int gap;
        bit [7:0] pin;
        bit sin;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        pin = 8'($urandom);
        sin = 1'($urandom);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        addr <= a;
        data <= d;
        parallel_in <= pin;
        serial_in_bit <= sin;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        n_sent++;
        expected_q.push_back(cpu_step(f, a, d, pin, sin));
    endtask

    task automatic ensure_byte(bit [15:0] a);
        if (!cpu_written[a])
            send_item(FUNC_WRITE, a, 8'($urandom));
    endtask

    // Execute one instruction, first writing whatever bytes it would read
    task automatic run_exec(bit allow_halt);
        bit [15:0] pa;
        bit [7:0] ins;
        bit [7:0] v;
        pa = {pch, pcl};
        if (!halt)
        begin
            if (!cpu_written[pa] || (!allow_halt && is_halting(cpu_mem[pa])))
            begin
                do
                    v = 8'($urandom);
                while (is_halting(v));
                send_item(FUNC_WRITE, pa, v);
            end
            ins = cpu_mem[pa];
            if (!ins[7] && ins[3:0] != D_CTRL
                && !(ins[3:0] == D_MEM && (ins[6:4] == S_IMM || ins[6:4] == S_MEM)))
            begin
                if (ins[6:4] == S_IMM)
                    ensure_byte({pch, pcl + 8'd1});
                else if (ins[6:4] == S_MEM)
                    ensure_byte(indirect_addr());
            end
            else if (ins[7:6] == 2'b11 && !ins[3])
                ensure_byte({ins[4] ? spage : gpage,
                             (ins[4] ? STACK_BASE : GLOBAL_BASE) + {5'd0, ins[2:0]}});
        end
        send_item(FUNC_EXEC, 16'd0, 8'd0);
    endtask

    // Place an instruction and its operand at pc, then execute it
    task automatic exec_ins(bit [7:0] ins, bit [7:0] opnd);
        send_item(FUNC_WRITE, {pch, pcl}, ins);
        send_item(FUNC_WRITE, {pch, pcl + 8'd1}, opnd);
        run_exec(1'b1);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            run_exec(1'b0);
        else if (r < 85)
            send_item(FUNC_WRITE, 16'($urandom), 8'($urandom));
        else if (r < 96)
            send_item(FUNC_READ, written_addrs[$urandom_range(0, written_addrs.size() - 1)],
                      8'($urandom));
        else
            send_item(FUNC_NONE, 16'($urandom), 8'($urandom));
    endtask

    task automatic test_memory_edges();
        send_item(FUNC_WRITE, 16'h0000, 8'h00);
        send_item(FUNC_WRITE, 16'hFFFF, 8'hFF);
        send_item(FUNC_READ, 16'hFFFF, 8'h00);
        send_item(FUNC_READ, 16'h0000, 8'hFF);
        send_item(FUNC_NONE, 16'hFFFF, 8'hFF);
    endtask

    task automatic test_alu_functions();
        exec_ins({1'b0, S_IMM, D_A}, 8'hFF);
        exec_ins({1'b0, S_IMM, D_B}, 8'h81);
        for (int fn = 0; fn < 16; fn++)
            exec_ins({1'b0, S_IMM, D_ALUF}, {4'($urandom_range(0, 15)), 4'(fn)});
        // frozen ALU returns the held value
        exec_ins({1'b0, S_IMM, D_A}, 8'h00);
        exec_ins({1'b0, S_ALU, D_PAGE}, 8'h00);
        exec_ins({1'b0, S_IMM, D_JZ}, 8'h40);
        exec_ins({1'b0, S_IMM, D_JNZ}, 8'h80);
    endtask

    task automatic test_signal_ops();
        exec_ins({1'b0, S_PIN, D_BUS}, 8'h00);
        exec_ins({1'b0, S_IMM, D_DEV}, 8'hA5);
        exec_ins({1'b0, S_IMM, D_GLOB}, 8'h12);
        for (int c = C_SSI; c <= C_LEAVE; c++)
            exec_ins({1'b0, 3'(c), D_CTRL}, 8'h00);
        exec_ins({1'b0, C_LEAVE, D_CTRL}, 8'h00);
        exec_ins({1'b0, S_SIN, D_RLO}, 8'h00);
        exec_ins(OP_TRAP | 8'h3F, 8'h00);
        exec_ins({1'b0, S_IMM, D_MEM}, 8'h00);
        exec_ins({1'b0, S_MEM, D_MEM}, 8'h00);
        exec_ins(OP_GETPUT | GP_STORE | GP_LOCAL | GP_ACCB | 8'h07, 8'h00);
        exec_ins(OP_GETPUT | GP_LOCAL | 8'h07, 8'h00);
        exec_ins(OP_GETPUT | GP_STORE, 8'h00);
        exec_ins(OP_GETPUT | GP_ACCB, 8'h00);
    endtask

    task automatic test_random_programs();
        while (n_sent < ITEM_TARGET)
        begin
            no_gaps = ((n_sent / 200) % 3) == 1;
            random_item();
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_output_backpressure();
        rx_hold = 300;
        no_gaps = 1'b1;
        repeat (40) run_exec(1'b0);
        no_gaps = 1'b0;
    endtask

    task automatic test_halt();
        exec_ins({1'b0, S_IMM, D_SER}, 8'hC3);
        run_exec(1'b1);
        run_exec(1'b1);
        send_item(FUNC_WRITE, 16'h1234, 8'h5A);
        send_item(FUNC_READ, 16'h1234, 8'h00);
    endtask

    // Receiver: random stall per transaction plus an optional long hold
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_stall <= 1'b1;
                rx_hold--;
            end
            else if (rx_wait > 0)
            begin
                out_stall <= 1'b1;
                rx_wait--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Result check against the oldest prediction
    always @(posedge clk)
    begin
        cpu_res_t got;
        cpu_res_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {pc, acc_a_out, acc_b_out, zero_out, halted_out, serial_out_bit,
                   serial_clock_out, bus_released, parallel_out, device_select_out,
                   read_data};
            if (expected_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: unexpected result %p", got);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: mismatch expected %p actual %p", exp_r, got);
                end
            end
            rx_wait = no_gaps ? 0 : $urandom_range(0, 6);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_NONE;
        addr = 16'd0;
        data = 8'd0;
        parallel_in = 8'd0;
        serial_in_bit = 1'b0;
        boff = 1'b1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        test_memory_edges();
        test_alu_functions();
        test_signal_ops();
        test_random_programs();
        test_output_backpressure();
        test_halt();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_err == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ accumulator_cpu_step_top.f @@
+incdir+design
design/acs_pkg.sv
design/acs_ctrl.sv
design/acs_dpath.sv
design/accumulator_cpu_step_top.sv
design/acs_checker.sv
dv/tb_top.sv
